// File: rtl/moving_average_window_assert.svh
// assertion macros shared by the moving average checker
// depends on a clock named clock and a reset named reset in the using scope
`ifndef MOVING_AVERAGE_WINDOW_ASSERT_SVH
`define MOVING_AVERAGE_WINDOW_ASSERT_SVH

// property checked outside reset
`define MAVW_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every edge, reset included
`define MAVW_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/mavw_pkg.sv
// shared widths, codes, types and helpers for the moving average window
// no dependencies
package mavw_pkg;

   localparam int MAX_WINDOW  = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int CFG_BITS    = 7;
   localparam int SLOT_BITS   = $clog2(MAX_WINDOW);
   localparam int COUNT_BITS  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;
   localparam int STEP_BITS   = $clog2(SUM_BITS + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LEVEL_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CFG_BITS-1:0] WINLEN_RESET = CFG_BITS'(8);

   // request kinds
   localparam logic REQ_PUSH   = 1'b0;
   localparam logic REQ_RESEED = 1'b1;

   // work handed from the front end to the divider
   typedef struct packed {
      logic signed [SUM_BITS-1:0] sum;
      logic [COUNT_BITS-1:0]      count;
   } job_type;

   // window length as used: zero acts as one, oversize clamps to the ring size
   function automatic logic [COUNT_BITS-1:0] effective_window(
      input logic [CFG_BITS-1:0] wl);
      logic [COUNT_BITS-1:0] win;
      if (wl == '0) begin
         win = COUNT_BITS'(1);
      end else if (wl > CFG_BITS'(MAX_WINDOW)) begin
         win = COUNT_BITS'(MAX_WINDOW);
      end else begin
         win = COUNT_BITS'(wl);
      end
      return win;
   endfunction

endpackage

// File: rtl/moving_average_window.sv
// moving average window top level: front end, job queue and divider
// an accepted transaction passes through the front end, the job queue and the 22-step divider to its result
// the divider is the bottleneck: it takes a new job only once its result register has been loaded
// reset: synchronous; clears sum, fill count and write slot, window length returns to 8
// the sample ring is not cleared, since only slots written since a clear are ever read
// depends on mavw_pkg, mavw_front, mavw_queue, mavw_divider
module moving_average_window (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_push,
   output logic                                     req_full,
   input  logic                                     req_type,
   input  logic signed [mavw_pkg::SAMPLE_BITS-1:0]  req_sample_value,
   output logic                                     rsp_empty,
   input  logic                                     rsp_pop,
   output logic signed [mavw_pkg::SAMPLE_BITS-1:0]  rsp_average,
   output logic [mavw_pkg::COUNT_BITS-1:0]          rsp_fill_level,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [mavw_pkg::CFG_BITS-1:0]            csr_window_length
);

   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_empty;
   mavw_pkg::job_type q_in_data;
   mavw_pkg::job_type q_out_data;

   // window bookkeeping
   mavw_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_type          (req_type),
      .req_sample_value  (req_sample_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_length (csr_window_length),
      .job_push          (q_push),
      .job_data          (q_in_data),
      .job_full          (q_full)
   );

   // decoupling queue
   mavw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .empty     (q_empty)
   );

   // averaging divide and result register
   mavw_divider u_divider (
      .clock          (clock),
      .reset          (reset),
      .job_empty      (q_empty),
      .job_data       (q_out_data),
      .job_pop        (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_average    (rsp_average),
      .rsp_fill_level (rsp_fill_level)
   );

endmodule

// File: rtl/mavw_front.sv
// front end: accepts requests, keeps the sample ring, running sum and fill count
// depends on mavw_pkg
module mavw_front (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_push,
   output logic                                      req_full,
   input  logic                                      req_type,
   input  logic signed [mavw_pkg::SAMPLE_BITS-1:0]   req_sample_value,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [mavw_pkg::CFG_BITS-1:0]             csr_window_length,
   output logic                                      job_push,
   output mavw_pkg::job_type                         job_data,
   input  logic                                      job_full
);

   typedef enum logic [1:0] {
      FE_IDLE   = 2'b01,
      FE_UPDATE = 2'b10
   } fe_state_type;

   fe_state_type                               state_ff, state_in;
   logic [mavw_pkg::COUNT_BITS-1:0]            win_ff, win_in;
   logic signed [mavw_pkg::SUM_BITS-1:0]       sum_ff, sum_in;
   logic [mavw_pkg::COUNT_BITS-1:0]            count_ff, count_in;
   logic [mavw_pkg::SLOT_BITS-1:0]             slot_ff, slot_in;
   logic                                       seed_active_ff, seed_active_in;
   logic signed [mavw_pkg::SAMPLE_BITS-1:0]    seed_ff;
   logic                                       kind_ff;
   logic signed [mavw_pkg::SAMPLE_BITS-1:0]    value_ff;
   logic signed [mavw_pkg::SAMPLE_BITS-1:0]    rd_ff;
   logic signed [mavw_pkg::SAMPLE_BITS-1:0]    ring [mavw_pkg::MAX_WINDOW];

   logic                                       accept;
   logic                                       ring_we;
   logic                                       seed_load;
   logic                                       last_slot;
   logic [mavw_pkg::COUNT_BITS-1:0]            win_minus_one;
   logic signed [mavw_pkg::SAMPLE_BITS-1:0]    old_sample;
   logic signed [mavw_pkg::SUM_BITS-1:0]       value_ext;
   logic signed [mavw_pkg::SUM_BITS-1:0]       old_ext;
   logic signed [mavw_pkg::SUM_BITS-1:0]       seed_sum;

   // handshakes
   assign req_full  = (state_ff != FE_IDLE);
   assign accept    = req_push && !req_full;
   assign csr_ready = 1'b1;

   // oldest sample: a slot not yet overwritten since a reseed holds the seed
   assign old_sample    = seed_active_ff ? seed_ff : rd_ff;
   assign value_ext     = {{mavw_pkg::SLOT_BITS{value_ff[mavw_pkg::SAMPLE_BITS-1]}}, value_ff};
   assign old_ext       = {{mavw_pkg::SLOT_BITS{old_sample[mavw_pkg::SAMPLE_BITS-1]}},
                           old_sample};
   assign seed_sum      = mavw_pkg::SUM_BITS'(value_ext * $signed({1'b0, win_ff}));
   assign win_minus_one = win_ff - mavw_pkg::COUNT_BITS'(1);
   assign last_slot     = (slot_ff == win_minus_one[mavw_pkg::SLOT_BITS-1:0]);

   // next state of the window
   always_comb begin
      state_in       = state_ff;
      win_in         = win_ff;
      sum_in         = sum_ff;
      count_in       = count_ff;
      slot_in        = slot_ff;
      seed_active_in = seed_active_ff;
      ring_we        = 1'b0;
      seed_load      = 1'b0;
      job_push       = 1'b0;
      unique case (state_ff)
         FE_IDLE: begin
            if (accept) begin
               state_in = FE_UPDATE;
            end
         end
         FE_UPDATE: begin
            if (!job_full) begin
               job_push = 1'b1;
               state_in = FE_IDLE;
               if (kind_ff == mavw_pkg::REQ_RESEED) begin
                  seed_load      = 1'b1;
                  seed_active_in = 1'b1;
                  count_in       = win_ff;
                  slot_in        = '0;
                  sum_in         = seed_sum;
               end else begin
                  ring_we = 1'b1;
                  if (count_ff < win_ff) begin
                     count_in = count_ff + mavw_pkg::COUNT_BITS'(1);
                     sum_in   = sum_ff + value_ext;
                  end else begin
                     sum_in = sum_ff - old_ext + value_ext;
                  end
                  if (last_slot) begin
                     slot_in        = '0;
                     seed_active_in = 1'b0;
                  end else begin
                     slot_in = slot_ff + mavw_pkg::SLOT_BITS'(1);
                  end
               end
            end
         end
         default: begin
            state_in = FE_IDLE;
         end
      endcase
      // window length write clears the window
      if (csr_valid && csr_ready) begin
         win_in         = mavw_pkg::effective_window(csr_window_length);
         sum_in         = '0;
         count_in       = '0;
         slot_in        = '0;
         seed_active_in = 1'b0;
      end
   end

   assign job_data = '{sum: sum_in, count: count_in};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= FE_IDLE;
         win_ff         <= mavw_pkg::effective_window(mavw_pkg::WINLEN_RESET);
         sum_ff         <= '0;
         count_ff       <= '0;
         slot_ff        <= '0;
         seed_active_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         win_ff         <= win_in;
         sum_ff         <= sum_in;
         count_ff       <= count_in;
         slot_ff        <= slot_in;
         seed_active_ff <= seed_active_in;
      end
   end

   // captured transaction and seed value
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_type;
         value_ff <= req_sample_value;
      end
      if (seed_load) begin
         seed_ff <= value_ff;
      end
   end

   // sample ring, registered read at the current write slot
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring[slot_ff] <= value_ff;
      end
      rd_ff <= ring[slot_ff];
   end

endmodule

// File: rtl/mavw_queue.sv
// short queue of divide jobs between the front end and the divider
// depends on mavw_pkg
module mavw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mavw_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output mavw_pkg::job_type pop_data,
   output logic              empty
);

   mavw_pkg::job_type                  entries [mavw_pkg::QUEUE_DEPTH];
   logic [mavw_pkg::PTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [mavw_pkg::PTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [mavw_pkg::LEVEL_BITS-1:0]    level_ff, level_in;
   logic                               do_push;
   logic                               do_pop;

   assign full     = (level_ff == mavw_pkg::LEVEL_BITS'(mavw_pkg::QUEUE_DEPTH));
   assign empty    = (level_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries[rd_ptr_ff];

   // pointer and level updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         if (wr_ptr_ff == mavw_pkg::PTR_BITS'(mavw_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + mavw_pkg::PTR_BITS'(1);
         end
      end
      if (do_pop) begin
         if (rd_ptr_ff == mavw_pkg::PTR_BITS'(mavw_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + mavw_pkg::PTR_BITS'(1);
         end
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + mavw_pkg::LEVEL_BITS'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - mavw_pkg::LEVEL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/mavw_divider.sv
// back end: radix-2 restoring divide of the running sum by the fill count,
// one quotient bit a cycle, into the result register; depends on mavw_pkg
module mavw_divider (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     job_empty,
   input  mavw_pkg::job_type                        job_data,
   output logic                                     job_pop,
   output logic                                     rsp_empty,
   input  logic                                     rsp_pop,
   output logic signed [mavw_pkg::SAMPLE_BITS-1:0]  rsp_average,
   output logic [mavw_pkg::COUNT_BITS-1:0]          rsp_fill_level
);

   typedef enum logic [2:0] {
      BE_IDLE = 3'b001,
      BE_DIV  = 3'b010,
      BE_DONE = 3'b100
   } be_state_type;

   be_state_type                              state_ff, state_in;
   logic [mavw_pkg::STEP_BITS-1:0]            step_ff, step_in;
   logic [mavw_pkg::COUNT_BITS-1:0]           rem_ff, rem_in;
   logic [mavw_pkg::SUM_BITS-1:0]             quo_ff, quo_in;
   logic [mavw_pkg::COUNT_BITS-1:0]           divisor_ff, divisor_in;
   logic                                      neg_ff, neg_in;
   logic                                      out_valid_ff, out_valid_in;
   logic signed [mavw_pkg::SAMPLE_BITS-1:0]   average_ff;
   logic [mavw_pkg::COUNT_BITS-1:0]           fill_ff;

   logic [mavw_pkg::COUNT_BITS:0]             shifted;
   logic [mavw_pkg::COUNT_BITS:0]             divisor_ext;
   logic                                      ge;
   logic [mavw_pkg::SUM_BITS-1:0]             quo_signed;
   logic signed [mavw_pkg::SAMPLE_BITS-1:0]   result;
   logic                                      out_load;

   // one restoring step
   assign shifted     = {rem_ff, quo_ff[mavw_pkg::SUM_BITS-1]};
   assign divisor_ext = {1'b0, divisor_ff};
   assign ge          = (shifted >= divisor_ext);

   // sign fix-up, empty window gives zero
   assign quo_signed = neg_ff ? (~quo_ff + mavw_pkg::SUM_BITS'(1)) : quo_ff;
   assign result     = (divisor_ff == '0) ? '0 : quo_signed[mavw_pkg::SAMPLE_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      divisor_in   = divisor_ff;
      neg_in       = neg_ff;
      job_pop      = 1'b0;
      out_load     = 1'b0;
      out_valid_in = out_valid_ff && !rsp_pop;
      unique case (state_ff)
         BE_IDLE: begin
            if (!job_empty) begin
               job_pop    = 1'b1;
               neg_in     = job_data.sum[mavw_pkg::SUM_BITS-1];
               quo_in     = job_data.sum[mavw_pkg::SUM_BITS-1]
                            ? mavw_pkg::SUM_BITS'(-job_data.sum)
                            : mavw_pkg::SUM_BITS'(job_data.sum);
               divisor_in = job_data.count;
               rem_in     = '0;
               step_in    = '0;
               state_in   = BE_DIV;
            end
         end
         BE_DIV: begin
            rem_in = ge ? mavw_pkg::COUNT_BITS'(shifted - divisor_ext)
                        : mavw_pkg::COUNT_BITS'(shifted);
            quo_in = {quo_ff[mavw_pkg::SUM_BITS-2:0], ge};
            if (step_ff == mavw_pkg::STEP_BITS'(mavw_pkg::SUM_BITS - 1)) begin
               state_in = BE_DONE;
            end else begin
               step_in = step_ff + mavw_pkg::STEP_BITS'(1);
            end
         end
         BE_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = BE_IDLE;
            end
         end
         default: begin
            state_in = BE_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BE_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      neg_ff     <= neg_in;
      if (out_load) begin
         average_ff <= result;
         fill_ff    <= divisor_ff;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_average    = average_ff;
   assign rsp_fill_level = fill_ff;

endmodule

// File: rtl/mavw_checker.sv
// port-level checks for the moving average window, bound to the top level
// depends on mavw_pkg and moving_average_window_assert.svh
`include "moving_average_window_assert.svh"

module mavw_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_push,
   input logic                                     req_full,
   input logic                                     rsp_empty,
   input logic                                     rsp_pop,
   input logic signed [mavw_pkg::SAMPLE_BITS-1:0]  rsp_average,
   input logic [mavw_pkg::COUNT_BITS-1:0]          rsp_fill_level
);

   // after reset nothing is pending and the input side is open
   `MAVW_ASSERT_ALWAYS(a_reset_state, ($past(reset) && !reset) |-> (rsp_empty && !req_full), "bad state after reset")

   // one transaction at a time: input closes right after an accept
   `MAVW_ASSERT(a_one_at_a_time, (req_push && !req_full) |=> req_full, "input open after accept")

   // a waiting result holds until taken
   `MAVW_ASSERT(a_result_holds, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_average) && $stable(rsp_fill_level)), "result changed while waiting")

   // fill level never exceeds the ring
   `MAVW_ASSERT(a_fill_range, !rsp_empty |-> (rsp_fill_level <= mavw_pkg::MAX_WINDOW), "fill level too large")

   // an empty window averages to zero
   `MAVW_ASSERT(a_empty_zero, (!rsp_empty && (rsp_fill_level == 0)) |-> (rsp_average == 0), "nonzero average of empty window")

endmodule

bind moving_average_window mavw_checker u_checker (.*);

// File: dv/tb_moving_average_window.sv
`timescale 1ns / 1ps
// self-checking testbench for moving_average_window: queue-style driver and monitor
// with random idling, a built-in boxcar predictor and per-field result checks
// depends on mavw_pkg and the moving_average_window rtl
module tb_moving_average_window;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int DRAIN_CYCLES  = 60;
   localparam int RANDOM_ITEMS  = 850;

   // one pending operation for the driver: a sample transaction or a window write
   typedef struct {
      bit                                      is_window_write;
      logic                                    kind;
      logic signed [mavw_pkg::SAMPLE_BITS-1:0] value;
      logic [mavw_pkg::CFG_BITS-1:0]           window_length;
   } pending_op_type;

   typedef struct packed {
      logic signed [mavw_pkg::SAMPLE_BITS-1:0] average;
      logic [mavw_pkg::COUNT_BITS-1:0]         fill_level;
   } average_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic req_type = mavw_pkg::REQ_PUSH;
   logic signed [mavw_pkg::SAMPLE_BITS-1:0] req_sample_value = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [mavw_pkg::SAMPLE_BITS-1:0] rsp_average;
   logic [mavw_pkg::COUNT_BITS-1:0] rsp_fill_level;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [mavw_pkg::CFG_BITS-1:0] csr_window_length = '0;

   pending_op_type     pending_ops[$];
   average_result_type expected_averages[$];
   int                 mismatch_count = 0;
   int                 cycle_count = 0;

   // predictor state
   logic signed [mavw_pkg::SAMPLE_BITS-1:0] window_samples [mavw_pkg::MAX_WINDOW];
   logic signed [mavw_pkg::SUM_BITS-1:0]    window_sum;
   logic [mavw_pkg::COUNT_BITS-1:0]         window_fill;
   logic [mavw_pkg::SLOT_BITS-1:0]          window_slot;
   logic [mavw_pkg::CFG_BITS-1:0]           window_setting;

   moving_average_window u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_type         (req_type),
      .req_sample_value (req_sample_value),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_average      (rsp_average),
      .rsp_fill_level   (rsp_fill_level),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_window_length(csr_window_length)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // random idle length: mostly none or short, now and then long, none at all in calm spells
   function automatic int idle_length(inout bit calm);
      int r;
      if ($urandom_range(0, 49) == 0) begin
         calm = !calm;
      end
      r = $urandom_range(0, 99);
      if (calm || r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 60);
   endfunction

   // clear the window and take a new length setting
   function automatic void clear_window(input logic [mavw_pkg::CFG_BITS-1:0] setting);
      window_setting = setting;
      window_sum     = '0;
      window_fill    = '0;
      window_slot    = '0;
   endfunction

   // advance the boxcar average by one sample transaction
   function automatic average_result_type average_next(
      input logic kind,
      input logic signed [mavw_pkg::SAMPLE_BITS-1:0] value);
      int win;
      int quotient;
      average_result_type res;
      if (window_setting == '0) begin
         win = 1;
      end else if (int'(window_setting) > mavw_pkg::MAX_WINDOW) begin
         win = mavw_pkg::MAX_WINDOW;
      end else begin
         win = int'(window_setting);
      end
      if (int'(window_slot) >= win) begin
         window_slot = '0;
      end
      if (kind == mavw_pkg::REQ_RESEED) begin
         for (int i = 0; i < win; i++) begin
            window_samples[i] = value;
         end
         window_fill = mavw_pkg::COUNT_BITS'(win);
         window_slot = '0;
         window_sum  = mavw_pkg::SUM_BITS'(int'(value) * win);
      end else begin
         // a full window loses its oldest sample before the overwrite
         if (int'(window_fill) < win) begin
            window_fill = window_fill + 1'b1;
         end else begin
            window_sum = window_sum - window_samples[window_slot];
         end
         window_samples[window_slot] = value;
         window_sum = window_sum + value;
         if (int'(window_slot) + 1 >= win) begin
            window_slot = '0;
         end else begin
            window_slot = window_slot + 1'b1;
         end
      end
      quotient = 0;
      if (window_fill != '0) begin
         quotient = int'(window_sum) / int'(window_fill);
      end
      res.average    = quotient[mavw_pkg::SAMPLE_BITS-1:0];
      res.fill_level = window_fill;
      return res;
   endfunction

   function automatic void add_sample(input logic kind, input int value);
      pending_op_type op;
      op.is_window_write = 1'b0;
      op.kind            = kind;
      op.value           = value[mavw_pkg::SAMPLE_BITS-1:0];
      op.window_length   = '0;
      pending_ops.push_back(op);
   endfunction

   function automatic void add_window_write(input int setting);
      pending_op_type op;
      op.is_window_write = 1'b1;
      op.kind            = mavw_pkg::REQ_PUSH;
      op.value           = '0;
      op.window_length   = setting[mavw_pkg::CFG_BITS-1:0];
      pending_ops.push_back(op);
   endfunction

   // driver: sample transactions, and window writes only once the block has drained
   bit req_calm = 1'b0;
   int req_idle = 0;
   always @(posedge clock) begin
      logic push_next;
      logic write_next;
      pending_op_type op;
      if (reset) begin
         req_push  <= 1'b0;
         csr_valid <= 1'b0;
         clear_window(mavw_pkg::WINLEN_RESET);
         req_idle = 0;
      end else begin
         push_next  = req_push;
         write_next = csr_valid;
         if (req_push && !req_full) begin
            expected_averages.push_back(average_next(req_type, req_sample_value));
            push_next = 1'b0;
            req_idle  = idle_length(req_calm);
         end
         if (csr_valid && csr_ready) begin
            clear_window(csr_window_length);
            write_next = 1'b0;
         end
         if (!push_next && !write_next) begin
            if (req_idle != 0) begin
               req_idle--;
            end else if (pending_ops.size() != 0) begin
               op = pending_ops[0];
               if (!op.is_window_write) begin
                  void'(pending_ops.pop_front());
                  push_next = 1'b1;
                  req_type         <= op.kind;
                  req_sample_value <= op.value;
               end else if (expected_averages.size() == 0) begin
                  void'(pending_ops.pop_front());
                  write_next = 1'b1;
                  csr_window_length <= op.window_length;
               end
            end
         end
         req_push  <= push_next;
         csr_valid <= write_next;
      end
   end

   // monitor: pop results with random stalls and compare against the oldest prediction
   bit rsp_calm = 1'b0;
   int rsp_idle = 0;
   always @(posedge clock) begin
      average_result_type exp_res;
      if (reset) begin
         rsp_pop <= 1'b0;
         rsp_idle = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_averages.size() == 0) begin
               $error("unexpected result transaction: average %0d, fill_level %0d",
                      rsp_average, rsp_fill_level);
               mismatch_count++;
            end else begin
               exp_res = expected_averages.pop_front();
               if (rsp_average !== exp_res.average) begin
                  $error("average mismatch: expected %0d, actual %0d",
                         exp_res.average, rsp_average);
                  mismatch_count++;
               end
               if (rsp_fill_level !== exp_res.fill_level) begin
                  $error("fill_level mismatch: expected %0d, actual %0d",
                         exp_res.fill_level, rsp_fill_level);
                  mismatch_count++;
               end
            end
            rsp_idle = idle_length(rsp_calm);
         end else if (rsp_idle != 0) begin
            rsp_idle--;
         end
         rsp_pop <= (rsp_idle == 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      int settings[$];
      int random_done;
      int phase;
      int run_left;
      int value_mode;
      int value;
      logic kind;

      // directed part at the reset window of eight
      add_sample(mavw_pkg::REQ_PUSH, 32767);
      add_sample(mavw_pkg::REQ_PUSH, -32768);
      add_sample(mavw_pkg::REQ_PUSH, 0);
      add_sample(mavw_pkg::REQ_PUSH, -1);
      add_sample(mavw_pkg::REQ_PUSH, 1);
      add_sample(mavw_pkg::REQ_PUSH, 32767);
      add_sample(mavw_pkg::REQ_PUSH, 32767);
      add_sample(mavw_pkg::REQ_PUSH, 32767);
      // window now full: these overwrite the oldest samples
      add_sample(mavw_pkg::REQ_PUSH, -32768);
      add_sample(mavw_pkg::REQ_PUSH, -32768);
      add_sample(mavw_pkg::REQ_RESEED, -32768);
      add_sample(mavw_pkg::REQ_PUSH, -32768);
      add_sample(mavw_pkg::REQ_RESEED, 32767);
      add_sample(mavw_pkg::REQ_PUSH, -7);
      // negative sum must truncate toward zero
      add_sample(mavw_pkg::REQ_RESEED, 0);
      add_sample(mavw_pkg::REQ_PUSH, -3);
      add_sample(mavw_pkg::REQ_PUSH, -9);
      add_sample(mavw_pkg::REQ_RESEED, -1);
      add_sample(mavw_pkg::REQ_PUSH, 2);

      // extremes first: smallest, largest, zero acting as one, oversize clamping to the ring
      settings = '{1, 64, 0, 127, 65, 2, 63, 3, 16, 33};
      random_done = 0;
      phase = 0;
      while (random_done < RANDOM_ITEMS) begin
         if (phase < settings.size()) begin
            add_window_write(settings[phase]);
         end else begin
            add_window_write($urandom_range(0, 127));
         end
         phase++;
         run_left = $urandom_range(30, 80);
         value_mode = 0;
         for (int n = 0; n < run_left && random_done < RANDOM_ITEMS; n++) begin
            // content style changes in short runs so sums reach their extremes
            if (n % 16 == 0) begin
               value_mode = $urandom_range(0, 5);
            end
            unique case (value_mode)
               1: begin
                  value = 32767;
               end
               2: begin
                  value = -32768;
               end
               3: begin
                  value = $urandom_range(0, 8) - 4;
               end
               4: begin
                  value = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
               end
               default: begin
                  value = int'($signed(16'($urandom)));
               end
            endcase
            kind = ($urandom_range(0, 11) == 0) ? mavw_pkg::REQ_RESEED : mavw_pkg::REQ_PUSH;
            add_sample(kind, value);
            random_done++;
         end
      end
      add_window_write(8);
      add_sample(mavw_pkg::REQ_PUSH, 100);
      add_sample(mavw_pkg::REQ_PUSH, -100);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      @(posedge clock);
      while (pending_ops.size() != 0 || req_push || csr_valid
             || expected_averages.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_averages.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
